// ===== design/nnsa_pkg.sv =====
// ----------------------------------------------------------------------------
// nnsa_pkg
// Shared widths, register indexes, sequencer states and divider types for
// the nearest-neighbor scale address generator.
// ----------------------------------------------------------------------------
package nnsa_pkg;

    localparam int ADDR_W     = 16;
    localparam int DIM_W      = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = 2 * DIM_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_BASE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_STRIDE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DST_BASE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DST_STRIDE    = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVX,
        ST_DIVY,
        ST_MUL,
        ST_ADJ,
        ST_STEP,
        ST_ROW
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] dividend;
        logic [DIM_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] quot;
        logic [DIM_W-1:0] rem;
    } div_rsp_t;

endpackage

// ===== design/nnsa_if.sv =====
// ----------------------------------------------------------------------------
// nnsa_if
// Valid/ready channels: step/start beats in, address pair beats out.
// ----------------------------------------------------------------------------
interface nnsa_in_if;
    logic valid;
    logic ready;
    logic begin_req;

    modport source (output valid, output begin_req, input ready);
    modport sink   (input valid, input begin_req, output ready);
endinterface

interface nnsa_out_if;
    logic                       valid;
    logic                       ready;
    logic                       valid_res;
    logic [nnsa_pkg::ADDR_W-1:0] src_addr;
    logic [nnsa_pkg::ADDR_W-1:0] dst_addr;
    logic                       row_end;
    logic                       image_end;

    modport source (output valid, output valid_res, output src_addr, output dst_addr,
                    output row_end, output image_end, input ready);
    modport sink   (input valid, input valid_res, input src_addr, input dst_addr,
                    input row_end, input image_end, output ready);
endinterface

// ===== design/nearest_neighbor_scale_addresser_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_addresser_unit
// Source/destination byte address generator for nearest-neighbor scaling.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake      payload
//  -------   ---   ------------   ---------------------------------------------
//  in_ch     in    valid/ready    begin_req
//  out_ch    out   valid/ready    valid_res, src_addr, dst_addr, row_end,
//                                 image_end
//  cfg       in    cfg_write      cfg_index, cfg_data (write only)
//
//  Every input beat yields exactly one output beat, loaded into the output
//  register in the cycle the input beat is taken.
//  Step beat: ST_STEP, plus ST_ROW on the last byte of a row; idle if no image
//  is open. Start beat: two passes of the shared restoring divider (load plus
//  nine quotient bits, x then y), a multiply state, an add state and the idle
//  state that takes the next beat; stays idle for an empty image. in_ch.ready
//  is low while the sequencer works or the output register holds a beat that
//  out_ch is not taking. Reset clears the sequencer and the active/valid flags.
//
module nearest_neighbor_scale_addresser_unit #(
    parameter int MAX_DIM = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    nnsa_in_if.sink                            in_ch,
    nnsa_out_if.source                         out_ch,
    input  logic                               cfg_write,
    input  logic [nnsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nnsa_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int AW    = nnsa_pkg::ADDR_W;
    localparam int DW    = nnsa_pkg::DIM_W;
    localparam int MD_W  = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (DW > MD_W) ? DW : MD_W;

    // dimensions above MAX_DIM are taken as MAX_DIM
    function automatic logic [DW-1:0] clamp_dim(input logic [DW-1:0] v);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(v);
        if (wide > CMP_W'(MAX_DIM))
            return DW'(MAX_DIM);
        else
            return v;
    endfunction

    // ---------------- configuration registers ----------------
    logic [AW-1:0] cfg_src_base_reg;
    logic [DW-1:0] cfg_src_width_reg;
    logic [DW-1:0] cfg_src_height_reg;
    logic [DW-1:0] cfg_src_stride_reg;
    logic [AW-1:0] cfg_dst_base_reg;
    logic [DW-1:0] cfg_dst_width_reg;
    logic [DW-1:0] cfg_dst_height_reg;
    logic [DW-1:0] cfg_dst_stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_src_base_reg   <= '0;
            cfg_src_width_reg  <= DW'(1);
            cfg_src_height_reg <= DW'(1);
            cfg_src_stride_reg <= DW'(1);
            cfg_dst_base_reg   <= '0;
            cfg_dst_width_reg  <= DW'(1);
            cfg_dst_height_reg <= DW'(1);
            cfg_dst_stride_reg <= DW'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                nnsa_pkg::REG_SRC_BASE:   cfg_src_base_reg   <= cfg_data;
                nnsa_pkg::REG_SRC_WIDTH:  cfg_src_width_reg  <= cfg_data[DW-1:0];
                nnsa_pkg::REG_SRC_HEIGHT: cfg_src_height_reg <= cfg_data[DW-1:0];
                nnsa_pkg::REG_SRC_STRIDE: cfg_src_stride_reg <= cfg_data[DW-1:0];
                nnsa_pkg::REG_DST_BASE:   cfg_dst_base_reg   <= cfg_data;
                nnsa_pkg::REG_DST_WIDTH:  cfg_dst_width_reg  <= cfg_data[DW-1:0];
                nnsa_pkg::REG_DST_HEIGHT: cfg_dst_height_reg <= cfg_data[DW-1:0];
                nnsa_pkg::REG_DST_STRIDE: cfg_dst_stride_reg <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- image state ----------------
    nnsa_pkg::state_t state_reg;
    nnsa_pkg::state_t state_next;

    logic          active_reg;
    logic [AW-1:0] lat_src_base_reg;
    logic [DW-1:0] lat_src_wb_reg;
    logic [DW-1:0] lat_src_h_reg;
    logic [DW-1:0] lat_src_stride_reg;
    logic [AW-1:0] lat_dst_base_reg;
    logic [DW-1:0] lat_dst_w_reg;
    logic [DW-1:0] lat_dst_h_reg;
    logic [DW-1:0] lat_dst_stride_reg;

    logic [AW-1:0] src_off_reg;
    logic [AW-1:0] dst_off_reg;
    logic [DW-1:0] col_left_reg;
    logic [DW-1:0] rows_left_reg;
    logic [DW-1:0] x_err_reg;
    logic [DW-1:0] y_err_reg;
    logic [DW-1:0] x_quot_reg;
    logic [DW-1:0] x_rem_reg;
    logic [DW-1:0] y_quot_reg;
    logic [DW-1:0] y_rem_reg;
    logic [AW-1:0] prod_reg;
    logic [AW-1:0] row_adj_reg;    // src_stride - 2*src_wb + y_quot*src_wb
    logic [AW-1:0] dst_adj_reg;    // dst_stride - dst_w

    // output register
    logic          out_valid_reg;
    logic          out_vres_reg;
    logic [AW-1:0] out_src_reg;
    logic [AW-1:0] out_dst_reg;
    logic          out_row_end_reg;
    logic          out_img_end_reg;

    nnsa_pkg::div_req_t div_req;
    nnsa_pkg::div_rsp_t div_rsp;

    logic                       in_acc;
    logic                       out_free;
    logic [DW-1:0]              src_wb_c;
    logic [DW-1:0]              src_h_c;
    logic [DW-1:0]              dst_w_c;
    logic [DW-1:0]              dst_h_c;
    logic                       zero_dims;
    logic                       last_col;
    logic                       last_row;
    logic [DW:0]                x_sum;
    logic                       x_carry;
    logic [DW-1:0]              x_err_next;
    logic [DW:0]                y_sum;
    logic                       y_carry;
    logic [DW-1:0]              y_err_next;
    logic [nnsa_pkg::PROD_W-1:0] prod_full;
    logic [AW-1:0]              row_extra;

    always_comb
    begin
        src_wb_c  = clamp_dim(cfg_src_width_reg);
        src_h_c   = clamp_dim(cfg_src_height_reg);
        dst_w_c   = clamp_dim(cfg_dst_width_reg);
        dst_h_c   = clamp_dim(cfg_dst_height_reg);
        zero_dims = (dst_w_c == '0) || (dst_h_c == '0);

        last_col  = (col_left_reg == DW'(1));
        last_row  = (rows_left_reg == DW'(1));

        // error terms stay below the divisor, so one conditional subtract wraps
        x_sum      = {1'b0, x_err_reg} + {1'b0, x_rem_reg};
        x_carry    = (x_sum >= {1'b0, lat_dst_w_reg});
        x_err_next = x_carry ? DW'(x_sum - {1'b0, lat_dst_w_reg}) : x_sum[DW-1:0];
        y_sum      = {1'b0, y_err_reg} + {1'b0, y_rem_reg};
        y_carry    = (y_sum >= {1'b0, lat_dst_h_reg});
        y_err_next = y_carry ? DW'(y_sum - {1'b0, lat_dst_h_reg}) : y_sum[DW-1:0];

        prod_full  = y_quot_reg * lat_src_wb_reg;
        row_extra  = y_carry ? AW'(lat_src_wb_reg) : '0;
    end

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == nnsa_pkg::ST_IDLE) && out_free;
    assign in_acc      = in_ch.valid && in_ch.ready;

    nnsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= nnsa_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        div_req    = '0;
        case (state_reg)
            nnsa_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (in_ch.begin_req)
                    begin
                        if (!zero_dims)
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = src_wb_c;
                            div_req.divisor  = dst_w_c;
                            state_next       = nnsa_pkg::ST_DIVX;
                        end
                    end
                    else if (active_reg)
                    begin
                        state_next = nnsa_pkg::ST_STEP;
                    end
                end
            end
            nnsa_pkg::ST_DIVX:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = lat_src_h_reg;
                    div_req.divisor  = lat_dst_h_reg;
                    state_next       = nnsa_pkg::ST_DIVY;
                end
            end
            nnsa_pkg::ST_DIVY:
            begin
                if (div_rsp.done)
                    state_next = nnsa_pkg::ST_MUL;
            end
            nnsa_pkg::ST_MUL:  state_next = nnsa_pkg::ST_ADJ;
            nnsa_pkg::ST_ADJ:  state_next = nnsa_pkg::ST_IDLE;
            nnsa_pkg::ST_STEP: state_next = last_col ? nnsa_pkg::ST_ROW : nnsa_pkg::ST_IDLE;
            nnsa_pkg::ST_ROW:  state_next = nnsa_pkg::ST_IDLE;
            default:           state_next = nnsa_pkg::ST_IDLE;
        endcase
    end

    // image-in-progress flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            active_reg <= 1'b0;
        else if (state_reg == nnsa_pkg::ST_IDLE && in_acc && in_ch.begin_req)
            active_reg <= !zero_dims;
        else if (state_reg == nnsa_pkg::ST_ROW && last_row)
            active_reg <= 1'b0;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            nnsa_pkg::ST_IDLE:
            begin
                if (in_acc && in_ch.begin_req)
                begin
                    lat_src_base_reg   <= cfg_src_base_reg;
                    lat_src_wb_reg     <= src_wb_c;
                    lat_src_h_reg      <= src_h_c;
                    lat_src_stride_reg <= cfg_src_stride_reg;
                    lat_dst_base_reg   <= cfg_dst_base_reg;
                    lat_dst_w_reg      <= dst_w_c;
                    lat_dst_h_reg      <= dst_h_c;
                    lat_dst_stride_reg <= cfg_dst_stride_reg;
                    src_off_reg        <= '0;
                    dst_off_reg        <= '0;
                    x_err_reg          <= '0;
                    y_err_reg          <= '0;
                    col_left_reg       <= dst_w_c;
                    rows_left_reg      <= dst_h_c;
                end
            end
            nnsa_pkg::ST_DIVX:
            begin
                if (div_rsp.done)
                begin
                    x_quot_reg <= div_rsp.quot;
                    x_rem_reg  <= div_rsp.rem;
                end
            end
            nnsa_pkg::ST_DIVY:
            begin
                if (div_rsp.done)
                begin
                    y_quot_reg <= div_rsp.quot;
                    y_rem_reg  <= div_rsp.rem;
                end
            end
            nnsa_pkg::ST_MUL:
            begin
                prod_reg <= prod_full[AW-1:0];
            end
            nnsa_pkg::ST_ADJ:
            begin
                row_adj_reg <= prod_reg + AW'(lat_src_stride_reg)
                               - AW'(lat_src_wb_reg) - AW'(lat_src_wb_reg);
                dst_adj_reg <= AW'(lat_dst_stride_reg) - AW'(lat_dst_w_reg);
            end
            nnsa_pkg::ST_STEP:
            begin
                src_off_reg  <= src_off_reg + AW'(x_quot_reg) + AW'(x_carry);
                dst_off_reg  <= dst_off_reg + AW'(1);
                x_err_reg    <= x_err_next;
                col_left_reg <= col_left_reg - DW'(1);
            end
            nnsa_pkg::ST_ROW:
            begin
                // row end: skip pitch, move by the y step, extra row on y wrap
                src_off_reg   <= src_off_reg + row_adj_reg + row_extra;
                dst_off_reg   <= dst_off_reg + dst_adj_reg;
                y_err_reg     <= y_err_next;
                rows_left_reg <= rows_left_reg - DW'(1);
                if (!last_row)
                begin
                    col_left_reg <= lat_dst_w_reg;
                    x_err_reg    <= '0;
                end
            end
            default: ;
        endcase
    end

    // output register: one beat per accepted input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_acc)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (!in_ch.begin_req && active_reg)
            begin
                out_vres_reg    <= 1'b1;
                out_src_reg     <= lat_src_base_reg + src_off_reg;
                out_dst_reg     <= lat_dst_base_reg + dst_off_reg;
                out_row_end_reg <= last_col;
                out_img_end_reg <= last_col && last_row;
            end
            else
            begin
                out_vres_reg    <= 1'b0;
                out_src_reg     <= '0;
                out_dst_reg     <= '0;
                out_row_end_reg <= 1'b0;
                out_img_end_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.valid_res = out_vres_reg;
    assign out_ch.src_addr  = out_src_reg;
    assign out_ch.dst_addr  = out_dst_reg;
    assign out_ch.row_end   = out_row_end_reg;
    assign out_ch.image_end = out_img_end_reg;

endmodule

// ===== design/nnsa_div.sv =====
// ----------------------------------------------------------------------------
// nnsa_div
// Restoring divider, one quotient bit per cycle, shared by x and y steps.
// ----------------------------------------------------------------------------
module nnsa_div (
    input  logic                clk,
    input  logic                rst_n,
    input  nnsa_pkg::div_req_t  req,
    output nnsa_pkg::div_rsp_t  rsp
);

    localparam int DW    = nnsa_pkg::DIM_W;
    localparam int CNT_W = $clog2(DW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    dvs_reg;

    logic [DW:0]      shifted;
    logic [DW:0]      diff;
    logic             fits;
    logic [DW-1:0]    rem_next;
    logic [DW-1:0]    quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = (shifted >= {1'b0, dvs_reg});
        rem_next = fits ? diff[DW-1:0] : shifted[DW-1:0];
        quo_next = {quo_reg[DW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== design/nnsa_checker.sv =====
// ----------------------------------------------------------------------------
// nnsa_checker
// Port-level checks for the scale address generator, bound to the top level.
// ----------------------------------------------------------------------------
module nnsa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        valid_res,
    input logic [nnsa_pkg::ADDR_W-1:0] src_addr,
    input logic [nnsa_pkg::ADDR_W-1:0] dst_addr,
    input logic                        row_end,
    input logic                        image_end
);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // every accepted beat shows up in the output register next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> out_valid)
        else $error("no result after accepted beat");

    // never take a beat while an undelivered result blocks the output
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> (!out_valid || out_ready))
        else $error("input taken over a pending result");

    a_empty_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |->
            (src_addr == '0 && dst_addr == '0 && !row_end && !image_end))
        else $error("empty result carries nonzero fields");

    a_image_end_on_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && image_end) |-> (row_end && valid_res))
        else $error("image end outside a row end");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(src_addr) && $stable(dst_addr) && $stable(valid_res)))
        else $error("stalled result changed");

endmodule

bind nearest_neighbor_scale_addresser_unit nnsa_checker u_nnsa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .valid_res (out_ch.valid_res),
    .src_addr  (out_ch.src_addr),
    .dst_addr  (out_ch.dst_addr),
    .row_end   (out_ch.row_end),
    .image_end (out_ch.image_end)
);
